/* rtl/hashed_timing_wheel_defines.svh */
// Assertion helpers used by the timing wheel top module.
`ifndef HASHED_TIMING_WHEEL_DEFINES_SVH
`define HASHED_TIMING_WHEEL_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define HTW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/htw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

    // Field widths.
    localparam int KEY_W    = 32;
    localparam int DELAY_W  = 24;
    localparam int SLOT_W   = 8;
    localparam int ROUND_W  = 24;
    localparam int DEN_W    = 16;
    localparam int SCNT_W   = 7;
    localparam int DCNT_W   = 5;

    // Defaults used when a configuration register holds zero.
    localparam logic [SCNT_W-1:0] DEFAULT_SLOTS    = 7'd10;
    localparam logic [DEN_W-1:0]  DEFAULT_INTERVAL = 16'd1000;

    // Input modes.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // Result events.
    localparam logic [2:0] EV_ADDED    = 3'd0;
    localparam logic [2:0] EV_REPLACED = 3'd1;
    localparam logic [2:0] EV_FULL     = 3'd2;
    localparam logic [2:0] EV_REMOVED  = 3'd3;
    localparam logic [2:0] EV_NOTFOUND = 3'd4;
    localparam logic [2:0] EV_EXPIRED  = 3'd5;

    // Configuration register indexes.
    localparam logic REG_SLOT_COUNT    = 1'b0;
    localparam logic REG_TICK_INTERVAL = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [KEY_W-1:0]   key;
        logic [DELAY_W-1:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [KEY_W-1:0] key_res;
        logic             last;
    } t_out_item;

    // One timer as held by a ring cell.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot;
        logic [ROUND_W-1:0] rounds;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/htw_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module htw_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire htw_pkg::t_entry i_next,
    output htw_pkg::t_entry     o_entry
);
    import htw_pkg::*;

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [SLOT_W-1:0]  r_slot;
    logic [ROUND_W-1:0] r_rounds;

    // The valid bit is control state and clears at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end
    end

    // Timer payload moves with the ring.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key    <= i_next.key;
            r_slot   <= i_next.slot;
            r_rounds <= i_next.rounds;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, slot: r_slot, rounds: r_rounds};

endmodule

`default_nettype wire

/* rtl/htw_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module htw_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [htw_pkg::DELAY_W-1:0] i_dividend,
    input  wire logic [htw_pkg::DEN_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [htw_pkg::DELAY_W-1:0]      o_quotient,
    output logic [htw_pkg::DEN_W-1:0]        o_remainder
);
    import htw_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W:0]    r_rem;
    logic [DELAY_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    w_sh;
    logic              w_ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign w_sh = {r_rem[DEN_W-1:0], r_quo[DELAY_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DCNT_W'(DELAY_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= {r_quo[DELAY_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[DEN_W-1:0];

endmodule

`default_nettype wire

/* rtl/hashed_timing_wheel.sv */
// Sequence: an add runs three chained serial divisions that hide the ring scan, then one ring
// write pass when a target entry was found; a remove runs one ring scan; a tick runs one ring scan
// and then a division that advances the wheel; each waits while the output stalls a result.
// Throughput: one transaction at a time; the ring of timer cells and the serial divider set it.
// Reset (synchronous, active low) clears every timer valid bit, the current slot and the
// configuration registers to 10 slots and an interval of 1000.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_timing_wheel_defines.svh"

module hashed_timing_wheel #(
    parameter int TIMER_ENTRIES = 16,
    parameter int WHEEL_SLOTS   = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire htw_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output htw_pkg::t_out_item   o_out_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import htw_pkg::*;

    localparam int IW = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_DIV      = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_FIN      = 3'd4;
    localparam logic [2:0] ST_ADV_GO   = 3'd5;
    localparam logic [2:0] ST_ADV_WAIT = 3'd6;

    localparam logic [1:0] DP_Q    = 2'd0;
    localparam logic [1:0] DP_R    = 2'd1;
    localparam logic [1:0] DP_S    = 2'd2;
    localparam logic [1:0] DP_DONE = 2'd3;

    // Configuration registers and the values actually used.
    logic [SCNT_W-1:0] r_slot_count;
    logic [DEN_W-1:0]  r_tick_interval;
    logic [SCNT_W-1:0] w_slots;
    logic [DEN_W-1:0]  w_interval;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count    <= DEFAULT_SLOTS;
            r_tick_interval <= DEFAULT_INTERVAL;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_SLOT_COUNT) begin
                r_slot_count <= pwdata[SCNT_W-1:0];
            end else begin
                r_tick_interval <= pwdata[DEN_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TICK_INTERVAL) ? {16'd0, r_tick_interval}
                                                     : {25'd0, r_slot_count};

    always_comb begin
        if (r_slot_count == '0) begin
            w_slots = DEFAULT_SLOTS;
        end else if ({2'b00, r_slot_count} > 9'(WHEEL_SLOTS)) begin
            w_slots = SCNT_W'(WHEEL_SLOTS);
        end else begin
            w_slots = r_slot_count;
        end
    end

    assign w_interval = (r_tick_interval == '0) ? DEFAULT_INTERVAL : r_tick_interval;

    // Ring of timer cells; cell 0 is the head that the controller looks at.
    t_entry w_cell [TIMER_ENTRIES];
    t_entry w_ret;
    logic   w_shift;

    for (genvar j = 0; j < TIMER_ENTRIES; j++) begin : g_cell
        t_entry w_next;
        if (j == TIMER_ENTRIES - 1) begin : g_tail
            assign w_next = w_ret;
        end else begin : g_mid
            assign w_next = w_cell[j+1];
        end
        htw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_next  (w_next),
            .o_entry (w_cell[j])
        );
    end

    // Shared serial divider.
    logic               d_start;
    logic [DELAY_W-1:0] d_dividend;
    logic [DEN_W-1:0]   d_divisor;
    logic               d_done;
    logic [DELAY_W-1:0] d_quo;
    logic [DEN_W-1:0]   d_rem;

    htw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (d_start),
        .i_dividend  (d_dividend),
        .i_divisor   (d_divisor),
        .o_done      (d_done),
        .o_quotient  (d_quo),
        .o_remainder (d_rem)
    );

    // Controller state.
    logic [2:0]         r_state, n_state;
    logic [IW-1:0]      r_step, n_step;
    logic [1:0]         r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [SLOT_W-1:0]  r_cur, n_cur;
    logic [1:0]         r_dph, n_dph;
    logic [ROUND_W-1:0] r_rounds, n_rounds;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_match_v, n_match_v;
    logic [IW-1:0]      r_match_idx, n_match_idx;
    logic               r_free_v, n_free_v;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic               r_pend_v, n_pend_v;
    logic [KEY_W-1:0]   r_pend_key, n_pend_key;
    logic               r_out_v, n_out_v;
    t_out_item          r_out_data, n_out_data;

    logic          w_out_free;
    logic          w_push;
    t_out_item     w_push_data;
    logic          w_accept;
    logic          w_last_step;
    logic          w_hit;
    logic [IW-1:0] w_target;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_v || !i_out_stall;
    assign w_last_step = (r_step == IW'(TIMER_ENTRIES - 1));
    assign w_hit       = w_cell[0].valid && (w_cell[0].key == r_key);
    assign w_target    = r_match_v ? r_match_idx : r_free_idx;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_mode      = r_mode;
        n_key       = r_key;
        n_cur       = r_cur;
        n_dph       = r_dph;
        n_rounds    = r_rounds;
        n_slot      = r_slot;
        n_match_v   = r_match_v;
        n_match_idx = r_match_idx;
        n_free_v    = r_free_v;
        n_free_idx  = r_free_idx;
        n_pend_v    = r_pend_v;
        n_pend_key  = r_pend_key;
        w_shift     = 1'b0;
        w_ret       = w_cell[0];
        w_push      = 1'b0;
        w_push_data = '{event_res: EV_EXPIRED, key_res: r_pend_key, last: 1'b0};
        d_start     = 1'b0;
        d_dividend  = i_in_data.delay;
        d_divisor   = w_interval;

        // Division chain for an add: delay/interval, then by slots, then the slot wrap.
        if (r_mode == MODE_ADD && d_done && r_state != ST_IDLE) begin
            unique case (r_dph)
                DP_Q: begin
                    d_start    = 1'b1;
                    d_dividend = d_quo;
                    d_divisor  = DEN_W'(w_slots);
                    n_dph      = DP_R;
                end
                DP_R: begin
                    n_rounds   = d_quo;
                    d_start    = 1'b1;
                    d_dividend = DELAY_W'(r_cur) + DELAY_W'(d_rem);
                    d_divisor  = DEN_W'(w_slots);
                    n_dph      = DP_S;
                end
                DP_S: begin
                    n_slot = d_rem[SLOT_W-1:0];
                    n_dph  = DP_DONE;
                end
                default: begin
                    n_dph = DP_DONE;
                end
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode    = i_in_data.mode;
                    n_key     = i_in_data.key;
                    n_step    = '0;
                    n_match_v = 1'b0;
                    n_free_v  = 1'b0;
                    n_pend_v  = 1'b0;
                    if (i_in_data.mode == MODE_ADD) begin
                        d_start = 1'b1;
                        n_dph   = DP_Q;
                        n_state = ST_SCAN;
                    end else if (i_in_data.mode == MODE_REMOVE
                                 || i_in_data.mode == MODE_TICK) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                w_shift = 1'b1;
                if (r_mode == MODE_ADD) begin
                    // Look for the key and for the lowest free entry.
                    if (w_hit) begin
                        n_match_v   = 1'b1;
                        n_match_idx = r_step;
                    end
                    if (!w_cell[0].valid && !r_free_v) begin
                        n_free_v   = 1'b1;
                        n_free_idx = r_step;
                    end
                end else if (r_mode == MODE_REMOVE) begin
                    if (w_hit) begin
                        n_match_v   = 1'b1;
                        w_ret.valid = 1'b0;
                    end
                end else begin
                    // Tick: age or expire timers of the current slot.
                    if (w_cell[0].valid && w_cell[0].slot == r_cur) begin
                        if (w_cell[0].rounds != '0) begin
                            w_ret.rounds = w_cell[0].rounds - 1'b1;
                        end else if (r_pend_v && !w_out_free) begin
                            w_shift = 1'b0;
                        end else begin
                            w_ret.valid = 1'b0;
                            w_push      = r_pend_v;
                            n_pend_v    = 1'b1;
                            n_pend_key  = w_cell[0].key;
                        end
                    end
                end
                if (w_shift) begin
                    n_step = r_step + 1'b1;
                    if (w_last_step) begin
                        n_step = '0;
                        if (r_mode == MODE_ADD) begin
                            n_state = ST_DIV;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (r_dph == DP_DONE) begin
                    if (r_match_v || r_free_v) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_WRITE: begin
                w_shift = 1'b1;
                if (r_step == w_target) begin
                    w_ret = '{valid: 1'b1, key: r_key, slot: r_slot, rounds: r_rounds};
                end
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_step  = '0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_mode == MODE_TICK) begin
                    if (!r_pend_v) begin
                        n_state = ST_ADV_GO;
                    end else if (w_out_free) begin
                        w_push      = 1'b1;
                        w_push_data = '{event_res: EV_EXPIRED, key_res: r_pend_key, last: 1'b1};
                        n_pend_v    = 1'b0;
                        n_state     = ST_ADV_GO;
                    end
                end else if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_mode == MODE_REMOVE) begin
                        w_push_data = '{event_res: r_match_v ? EV_REMOVED : EV_NOTFOUND,
                                        key_res: r_key, last: 1'b1};
                    end else begin
                        w_push_data = '{event_res: r_match_v ? EV_REPLACED
                                                   : (r_free_v ? EV_ADDED : EV_FULL),
                                        key_res: r_key, last: 1'b1};
                    end
                end
            end
            ST_ADV_GO: begin
                // Advance the wheel: (current + 1) mod slots.
                d_start    = 1'b1;
                d_dividend = DELAY_W'(r_cur) + 1'b1;
                d_divisor  = DEN_W'(w_slots);
                n_state    = ST_ADV_WAIT;
            end
            ST_ADV_WAIT: begin
                if (d_done) begin
                    n_cur   = d_rem[SLOT_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output register: loads on a push, empties when the transaction is taken.
        if (w_push) begin
            n_out_v    = 1'b1;
            n_out_data = w_push_data;
        end else begin
            n_out_v    = r_out_v && i_out_stall;
            n_out_data = r_out_data;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_step   <= '0;
            r_dph    <= DP_DONE;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_step   <= n_step;
            r_dph    <= n_dph;
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_key       <= n_key;
        r_rounds    <= n_rounds;
        r_slot      <= n_slot;
        r_match_v   <= n_match_v;
        r_match_idx <= n_match_idx;
        r_free_v    <= n_free_v;
        r_free_idx  <= n_free_idx;
        r_pend_key  <= n_pend_key;
        r_out_data  <= n_out_data;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;

    // A write pass only starts with a known target entry.
    `HTW_ASSERT_NOW(a_write_target, r_state == ST_WRITE, r_match_v || r_free_v,
                    "write pass without a target entry")
    // A held expiry only exists while a tick is in progress.
    `HTW_ASSERT_NOW(a_pend_tick, r_pend_v, r_mode == MODE_TICK && r_state != ST_IDLE,
                    "pending expiry outside a tick")
    // The final tick result empties the pending holder before the wheel advances.
    `HTW_ASSERT_NEXT(a_adv_clean, r_state == ST_ADV_GO, !r_pend_v,
                     "wheel advanced with an expiry still pending")

endmodule

`default_nettype wire
